@@ design/hbf_pkg.sv @@
// Shared types, widths and constants of the height band fog strength block.
`default_nettype none
package hbf_pkg;
  localparam int COORD_W   = 24;
  localparam int RANGE_W   = 23;
  localparam int FOG_W     = 16;
  localparam int MAG_W     = 24;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int LEN_W     = SUM_W / 2;
  localparam int SQ_REM_W  = LEN_W + 3;
  localparam int NUM_LO_W  = 12;
  localparam int PLO_W     = LEN_W + NUM_LO_W;
  localparam int PHI_W     = LEN_W + MAG_W - NUM_LO_W;
  localparam int PROD_W    = LEN_W + MAG_W;
  localparam int REG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [FOG_W-1:0]   FULL_STRENGTH     = 16'hFFFF;
  localparam logic [COORD_W-1:0] FOG_CEILING_RESET = 24'd102400;
  localparam logic [RANGE_W-1:0] DEPTH_RANGE_RESET = 23'd896000;
  localparam logic [RANGE_W-1:0] FAR_DIST_RESET    = 23'd5120000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_CAMERA_Z    = 3'd2,
    REG_FOG_FLOOR   = 3'd3,
    REG_FOG_CEILING = 3'd4,
    REG_DEPTH_RANGE = 3'd5,
    REG_FAR_DIST    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] camera_x;
    logic [COORD_W-1:0] camera_y;
    logic [COORD_W-1:0] camera_z;
    logic [COORD_W-1:0] fog_floor;
    logic [COORD_W-1:0] fog_ceiling;
    logic [RANGE_W-1:0] fog_depth_range;
    logic [RANGE_W-1:0] far_distance;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_sq;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] num;
    logic             same_side;
    logic             ay_zero;
  } mid_item_t;

  typedef struct packed {
    logic empty;
    logic room;
  } mid_stat_t;
endpackage
`default_nettype wire

@@ design/hbf_front.sv @@
// Front part: deltas, slab classification, clipped height span and squares.
`default_nettype none
module hbf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        accept,
  input  wire logic [hbf_pkg::COORD_W-1:0] point_x,
  input  wire logic [hbf_pkg::COORD_W-1:0] point_y,
  input  wire logic [hbf_pkg::COORD_W-1:0] point_z,
  input  wire hbf_pkg::cfg_t               cfg,
  output logic                             out_valid,
  output hbf_pkg::mid_item_t               out_item
);
  import hbf_pkg::*;

  function automatic logic [MAG_W-1:0] mag(input logic signed [COORD_W:0] d);
    logic signed [COORD_W:0] n;
    n = d[COORD_W] ? -d : d;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] clip(input logic signed [COORD_W-1:0] y,
      input logic signed [COORD_W-1:0] lo, input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W-1:0] r;
    if (y > hi) r = hi;
    else if (y < lo) r = lo;
    else r = y;
    return r;
  endfunction

  logic signed [COORD_W-1:0] py, cy, lo, hi, cp, cc;
  logic signed [COORD_W:0]   dx, dy, dz, dcl;
  logic [MAG_W-1:0]          ax_c, ay_c, az_c, ncl, num_c;
  logic                      same_c;

  always_comb begin
    py = $signed(point_y);
    cy = $signed(cfg.camera_y);
    lo = $signed(cfg.fog_floor);
    hi = $signed(cfg.fog_ceiling);
    dx = $signed({point_x[COORD_W-1], point_x}) - $signed({cfg.camera_x[COORD_W-1], cfg.camera_x});
    dy = $signed({point_y[COORD_W-1], point_y}) - $signed({cfg.camera_y[COORD_W-1], cfg.camera_y});
    dz = $signed({point_z[COORD_W-1], point_z}) - $signed({cfg.camera_z[COORD_W-1], cfg.camera_z});
    ax_c = mag(dx);
    ay_c = mag(dy);
    az_c = mag(dz);
    same_c = (cy < lo && py < lo) || (cy > hi && py > hi);
    cp = clip(py, lo, hi);
    cc = clip(cy, lo, hi);
    dcl = $signed({cp[COORD_W-1], cp}) - $signed({cc[COORD_W-1], cc});
    ncl = mag(dcl);
    num_c = (ncl > ay_c) ? ay_c : ncl;
  end

  logic             v1, v2, v3;
  logic [MAG_W-1:0] ax1, ay1, az1, num1, ay2, num2;
  logic             same1, ayz1, same2, ayz2;
  logic [SQ_W-1:0]  sqx, sqy, sqz;
  mid_item_t        item3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1   <= ax_c;
      ay1   <= ay_c;
      az1   <= az_c;
      num1  <= num_c;
      same1 <= same_c;
      ayz1  <= (ay_c == '0);
      sqx   <= SQ_W'(ax1) * SQ_W'(ax1);
      sqy   <= SQ_W'(ay1) * SQ_W'(ay1);
      sqz   <= SQ_W'(az1) * SQ_W'(az1);
      ay2   <= ay1;
      num2  <= num1;
      same2 <= same1;
      ayz2  <= ayz1;
      item3.sum_sq    <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
      item3.ay        <= ay2;
      item3.num       <= num2;
      item3.same_side <= same2;
      item3.ay_zero   <= ayz2;
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;
endmodule
`default_nettype wire

@@ design/hbf_fifo.sv @@
// Short item queue between the front and back parts.
`default_nettype none
module hbf_fifo #(
  parameter int DEPTH = hbf_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire hbf_pkg::mid_item_t wr_item,
  input  wire logic               rd,
  output hbf_pkg::mid_item_t      rd_item,
  output hbf_pkg::mid_stat_t      stat
);
  import hbf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mid_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_item    = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.room  = (count < CNT_W'(DEPTH - 1));
endmodule
`default_nettype wire

@@ design/hbf_back.sv @@
// Back part: pipelined square root, in-slab scaling, strength dividers, result queue.
`default_nettype none
module hbf_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire hbf_pkg::mid_item_t in_item,
  input  wire hbf_pkg::cfg_t      cfg,
  input  wire logic               pop,
  output logic                    in_take,
  output logic                    empty,
  output logic [hbf_pkg::FOG_W-1:0] ground_fog,
  output logic [hbf_pkg::FOG_W-1:0] distance_fog
);
  import hbf_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] num;
    logic             same_side;
    logic             ay_zero;
  } meta_t;

  localparam int SQL = LEN_W - 1;
  localparam int DVL = LEN_W - 1;
  localparam int STL = FOG_W - 1;

  logic [1:0] oq_count;
  logic       en;
  assign en      = (oq_count != 2'd2);
  assign in_take = en & in_valid;

  // square root, one result bit per stage
  logic                sq_v    [LEN_W];
  logic [SQ_REM_W-1:0] sq_rem  [LEN_W];
  logic [LEN_W-1:0]    sq_root [LEN_W];
  logic [SUM_W-1:0]    sq_rad  [LEN_W];
  meta_t               sq_meta [LEN_W];
  logic [SQ_REM_W-1:0] sq_rem_n  [LEN_W];
  logic [LEN_W-1:0]    sq_root_n [LEN_W];
  logic [SUM_W-1:0]    sq_rad_n  [LEN_W];

  always_comb begin
    logic [SQ_REM_W-1:0] s_rem, r2, trial;
    logic [LEN_W-1:0]    s_root;
    logic [SUM_W-1:0]    s_rad;
    logic                ge;
    for (int k = 0; k < LEN_W; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_rad  = in_item.sum_sq;
      end else begin
        s_rem  = sq_rem[k-1];
        s_root = sq_root[k-1];
        s_rad  = sq_rad[k-1];
      end
      r2    = {s_rem[SQ_REM_W-3:0], s_rad[SUM_W-1 -: 2]};
      trial = SQ_REM_W'({s_root, 2'b01});
      ge    = (r2 >= trial);
      sq_rem_n[k]  = ge ? r2 - trial : r2;
      sq_root_n[k] = {s_root[LEN_W-2:0], ge};
      sq_rad_n[k]  = {s_rad[SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEN_W; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < LEN_W; k++) sq_v[k] <= (k == 0) ? in_take : sq_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LEN_W; k++) begin
        sq_rem[k]  <= sq_rem_n[k];
        sq_root[k] <= sq_root_n[k];
        sq_rad[k]  <= sq_rad_n[k];
        sq_meta[k] <= (k == 0) ? meta_t'({in_item.ay, in_item.num, in_item.same_side,
                                          in_item.ay_zero}) : sq_meta[k-1];
      end
    end
  end

  // len * num in two partial products
  logic             m1_v, m2_v;
  logic [PLO_W-1:0] m1_plo;
  logic [PHI_W-1:0] m1_phi;
  logic [LEN_W-1:0] m1_len, m2_len;
  meta_t            m1_meta, m2_meta;
  logic [PROD_W-1:0] m2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
    end else if (en) begin
      m1_v <= sq_v[SQL];
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_plo  <= PLO_W'(sq_root[SQL]) * PLO_W'(sq_meta[SQL].num[NUM_LO_W-1:0]);
      m1_phi  <= PHI_W'(sq_root[SQL]) * PHI_W'(sq_meta[SQL].num[MAG_W-1:NUM_LO_W]);
      m1_len  <= sq_root[SQL];
      m1_meta <= sq_meta[SQL];
      m2_prod <= PROD_W'(m1_plo) + (PROD_W'(m1_phi) << NUM_LO_W);
      m2_len  <= m1_len;
      m2_meta <= m1_meta;
    end
  end

  // product / ay, one quotient bit per stage
  logic             dv_v    [LEN_W];
  logic [MAG_W-1:0] dv_rem  [LEN_W];
  logic [LEN_W-1:0] dv_low  [LEN_W];
  logic [LEN_W-1:0] dv_q    [LEN_W];
  logic [LEN_W-1:0] dv_len  [LEN_W];
  meta_t            dv_meta [LEN_W];
  logic [MAG_W-1:0] dv_rem_n [LEN_W];
  logic [LEN_W-1:0] dv_low_n [LEN_W];
  logic [LEN_W-1:0] dv_q_n   [LEN_W];

  always_comb begin
    logic [MAG_W-1:0] s_rem, s_ay;
    logic [LEN_W-1:0] s_low, s_q;
    logic [MAG_W:0]   t, d;
    logic             ge;
    for (int k = 0; k < LEN_W; k++) begin
      if (k == 0) begin
        s_rem = m2_prod[PROD_W-1:LEN_W];
        s_low = m2_prod[LEN_W-1:0];
        s_q   = '0;
        s_ay  = m2_meta.ay;
      end else begin
        s_rem = dv_rem[k-1];
        s_low = dv_low[k-1];
        s_q   = dv_q[k-1];
        s_ay  = dv_meta[k-1].ay;
      end
      t  = {s_rem, s_low[LEN_W-1]};
      ge = (t >= {1'b0, s_ay});
      d  = t - {1'b0, s_ay};
      dv_rem_n[k] = ge ? d[MAG_W-1:0] : t[MAG_W-1:0];
      dv_low_n[k] = {s_low[LEN_W-2:0], 1'b0};
      dv_q_n[k]   = {s_q[LEN_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LEN_W; k++) dv_v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < LEN_W; k++) dv_v[k] <= (k == 0) ? m2_v : dv_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LEN_W; k++) begin
        dv_rem[k]  <= dv_rem_n[k];
        dv_low[k]  <= dv_low_n[k];
        dv_q[k]    <= dv_q_n[k];
        dv_len[k]  <= (k == 0) ? m2_len : dv_len[k-1];
        dv_meta[k] <= (k == 0) ? m2_meta : dv_meta[k-1];
      end
    end
  end

  // strength setup: saturation check, then Q0.16 quotient
  logic             ss_v, ss_gsat, ss_dsat, ss_same;
  logic [LEN_W-1:0] ss_inside, ss_len;
  logic [LEN_W-1:0] inside_c;
  assign inside_c = dv_meta[DVL].ay_zero ? dv_len[DVL] : dv_q[DVL];

  always_ff @(posedge clk) begin
    if (rst) ss_v <= 1'b0;
    else if (en) ss_v <= dv_v[DVL];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss_inside <= inside_c;
      ss_len    <= dv_len[DVL];
      ss_gsat   <= (inside_c >= LEN_W'(cfg.fog_depth_range));
      ss_dsat   <= (dv_len[DVL] >= LEN_W'(cfg.far_distance));
      ss_same   <= dv_meta[DVL].same_side;
    end
  end

  logic               st_v    [FOG_W];
  logic [RANGE_W-1:0] gr_rem  [FOG_W];
  logic [FOG_W-1:0]   gr_q    [FOG_W];
  logic [RANGE_W-1:0] dr_rem  [FOG_W];
  logic [FOG_W-1:0]   dr_q    [FOG_W];
  logic               st_gsat [FOG_W];
  logic               st_dsat [FOG_W];
  logic               st_same [FOG_W];
  logic [RANGE_W-1:0] gr_rem_n [FOG_W];
  logic [FOG_W-1:0]   gr_q_n   [FOG_W];
  logic [RANGE_W-1:0] dr_rem_n [FOG_W];
  logic [FOG_W-1:0]   dr_q_n   [FOG_W];

  always_comb begin
    logic [RANGE_W-1:0] g_rem, d_rem;
    logic [FOG_W-1:0]   g_q, d_q;
    logic [RANGE_W:0]   gt, dt, gd, dd;
    logic               gge, dge;
    for (int k = 0; k < FOG_W; k++) begin
      if (k == 0) begin
        g_rem = ss_inside[RANGE_W-1:0];
        d_rem = ss_len[RANGE_W-1:0];
        g_q   = '0;
        d_q   = '0;
      end else begin
        g_rem = gr_rem[k-1];
        d_rem = dr_rem[k-1];
        g_q   = gr_q[k-1];
        d_q   = dr_q[k-1];
      end
      gt  = {g_rem, 1'b0};
      dt  = {d_rem, 1'b0};
      gge = (gt >= {1'b0, cfg.fog_depth_range});
      dge = (dt >= {1'b0, cfg.far_distance});
      gd  = gt - {1'b0, cfg.fog_depth_range};
      dd  = dt - {1'b0, cfg.far_distance};
      gr_rem_n[k] = gge ? gd[RANGE_W-1:0] : gt[RANGE_W-1:0];
      dr_rem_n[k] = dge ? dd[RANGE_W-1:0] : dt[RANGE_W-1:0];
      gr_q_n[k]   = {g_q[FOG_W-2:0], gge};
      dr_q_n[k]   = {d_q[FOG_W-2:0], dge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FOG_W; k++) st_v[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < FOG_W; k++) st_v[k] <= (k == 0) ? ss_v : st_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < FOG_W; k++) begin
        gr_rem[k]  <= gr_rem_n[k];
        dr_rem[k]  <= dr_rem_n[k];
        gr_q[k]    <= gr_q_n[k];
        dr_q[k]    <= dr_q_n[k];
        st_gsat[k] <= (k == 0) ? ss_gsat : st_gsat[k-1];
        st_dsat[k] <= (k == 0) ? ss_dsat : st_dsat[k-1];
        st_same[k] <= (k == 0) ? ss_same : st_same[k-1];
      end
    end
  end

  // two-entry result queue
  logic [FOG_W-1:0] oq_g [2];
  logic [FOG_W-1:0] oq_d [2];
  logic             oq_wp, oq_rp, oq_wr, oq_rd;
  logic [FOG_W-1:0] g_fin, d_fin;

  assign g_fin = st_same[STL] ? '0 : (st_gsat[STL] ? FULL_STRENGTH : gr_q[STL]);
  assign d_fin = st_dsat[STL] ? FULL_STRENGTH : dr_q[STL];
  assign oq_wr = en & st_v[STL];
  assign oq_rd = pop & (oq_count != 2'd0);

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_g[oq_wp] <= g_fin;
      oq_d[oq_wp] <= d_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp    <= 1'b0;
      oq_rp    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (oq_wr) oq_wp <= ~oq_wp;
      if (oq_rd) oq_rp <= ~oq_rp;
      case ({oq_wr, oq_rd})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

  assign empty        = (oq_count == 2'd0);
  assign ground_fog   = oq_g[oq_rp];
  assign distance_fog = oq_d[oq_rp];

`ifndef SYNTH
  a_oq_bound: assert property (@(posedge clk) disable iff (rst) oq_count != 2'd3)
    else $error("result queue overflow");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      (st_v[STL] && !en) |=> st_v[STL])
    else $error("stalled result lost");
  a_pop_drain: assert property (@(posedge clk) disable iff (rst)
      (oq_rd && !oq_wr) |=> (oq_count == $past(oq_count) - 2'd1))
    else $error("result queue count wrong after pop");
`endif
endmodule
`default_nettype wire

@@ design/height_band_fog_strength_core.sv @@
// Throughput: one item per cycle while the result queue and the front/back queue have
// room; the square root, in-slab divider and strength dividers are fully pipelined, one
// bit per stage, so one new item enters each clock while neither queue stalls the flow.
// Full rises when the 4-entry front/back queue nears its end; empty tracks the 2-entry
// result queue. Reset (rst, synchronous) clears all valid state and loads register defaults.
`default_nettype none
module height_band_fog_strength_core #(
  parameter int QUEUE_DEPTH = hbf_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [hbf_pkg::COORD_W-1:0]   point_x,
  input  wire logic [hbf_pkg::COORD_W-1:0]   point_y,
  input  wire logic [hbf_pkg::COORD_W-1:0]   point_z,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [hbf_pkg::FOG_W-1:0]          ground_fog,
  output logic [hbf_pkg::FOG_W-1:0]          distance_fog,
  input  wire logic                          cfg_write,
  input  wire logic [hbf_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [hbf_pkg::COORD_W-1:0]   cfg_data
);
  import hbf_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_x        <= '0;
      cfg.camera_y        <= '0;
      cfg.camera_z        <= '0;
      cfg.fog_floor       <= '0;
      cfg.fog_ceiling     <= FOG_CEILING_RESET;
      cfg.fog_depth_range <= DEPTH_RANGE_RESET;
      cfg.far_distance    <= FAR_DIST_RESET;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_CAMERA_X:    cfg.camera_x        <= cfg_data;
        REG_CAMERA_Y:    cfg.camera_y        <= cfg_data;
        REG_CAMERA_Z:    cfg.camera_z        <= cfg_data;
        REG_FOG_FLOOR:   cfg.fog_floor       <= cfg_data;
        REG_FOG_CEILING: cfg.fog_ceiling     <= cfg_data;
        REG_DEPTH_RANGE: cfg.fog_depth_range <= cfg_data[RANGE_W-1:0];
        REG_FAR_DIST:    cfg.far_distance    <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  mid_stat_t mid_stat;
  mid_item_t front_item, mid_item;
  logic      front_valid, front_en, back_take;

  assign front_en = mid_stat.room;
  assign full     = ~front_en;

  hbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .accept    (push & front_en),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .cfg       (cfg),
    .out_valid (front_valid),
    .out_item  (front_item)
  );

  hbf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_en & front_valid),
    .wr_item (front_item),
    .rd      (back_take),
    .rd_item (mid_item),
    .stat    (mid_stat)
  );

  hbf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (~mid_stat.empty),
    .in_item      (mid_item),
    .cfg          (cfg),
    .pop          (pop),
    .in_take      (back_take),
    .empty        (empty),
    .ground_fog   (ground_fog),
    .distance_fog (distance_fog)
  );
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the height band fog strength core: directed and random points vs. a model.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import hbf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  logic [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [FOG_W-1:0] ground_fog, distance_fog;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic [FOG_W-1:0] ground;
    logic [FOG_W-1:0] dist_fog;
  } fog_pair_t;

  fog_pair_t fog_q[$];
  cfg_t cfg;
  int errors = 0;
  int idle_cycles = 0;
  int push_idle_pct = 0;
  int pop_idle_pct = 0;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LATENCY = 76;

  height_band_fog_strength_core dut (.*);

  always #4 clk = ~clk;

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [FOG_W-1:0] fog_ratio(input logic [63:0] len,
                                                  input logic [RANGE_W-1:0] dv);
    logic [63:0] q;
    if (dv == 0) return FULL_STRENGTH;
    q = (len << 16) / dv;
    return q > 64'hFFFF ? FULL_STRENGTH : q[FOG_W-1:0];
  endfunction

  function automatic longint clamp_h(input longint y, input longint lo, input longint hi);
    if (y > hi) return hi;
    if (y < lo) return lo;
    return y;
  endfunction

  function automatic fog_pair_t predict_fog(input logic [COORD_W-1:0] x, y, z);
    longint cy, py, lo, hi;
    logic [63:0] ax, ay, az, len, num, in_slab;
    fog_pair_t r;
    cy = longint'($signed(cfg.camera_y));
    py = longint'($signed(y));
    lo = longint'($signed(cfg.fog_floor));
    hi = longint'($signed(cfg.fog_ceiling));
    ax = mag64(longint'($signed(x)) - longint'($signed(cfg.camera_x)));
    ay = mag64(py - cy);
    az = mag64(longint'($signed(z)) - longint'($signed(cfg.camera_z)));
    len = root_floor(ax * ax + ay * ay + az * az);
    if ((cy < lo && py < lo) || (cy > hi && py > hi)) begin
      r.ground = '0;
    end else begin
      if (ay == 0) begin
        in_slab = len;
      end else begin
        num = mag64(clamp_h(py, lo, hi) - clamp_h(cy, lo, hi));
        if (num > ay) num = ay;
        in_slab = (len * num) / ay;
      end
      r.ground = fog_ratio(in_slab, cfg.fog_depth_range);
    end
    r.dist_fog = fog_ratio(len, cfg.far_distance);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // watchdog and pop driver
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
    pop <= !rst && ($urandom_range(99) >= pop_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    fog_pair_t e;
    if (!rst && pop && !empty) begin
      if (fog_q.size() == 0) begin
        report_mismatch("item with no expectation");
      end else begin
        e = fog_q.pop_front();
        if (ground_fog !== e.ground)
          report_mismatch($sformatf("ground_fog %0d exp %0d", ground_fog, e.ground));
        if (distance_fog !== e.dist_fog)
          report_mismatch($sformatf("distance_fog %0d exp %0d", distance_fog, e.dist_fog));
      end
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, y, z);
    if ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < push_idle_pct) @(posedge clk);
    end
    push <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    fog_q.push_back(predict_fog(x, y, z));
  endtask

  task automatic drain;
    push <= 1'b0;
    while (fog_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CAMERA_X: cfg.camera_x = v;
      REG_CAMERA_Y: cfg.camera_y = v;
      REG_CAMERA_Z: cfg.camera_z = v;
      REG_FOG_FLOOR: cfg.fog_floor = v;
      REG_FOG_CEILING: cfg.fog_ceiling = v;
      REG_DEPTH_RANGE: cfg.fog_depth_range = v[RANGE_W-1:0];
      REG_FAR_DIST: cfg.far_distance = v[RANGE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(8000)) - 4000);
      2: return COORD_W'($signed($urandom_range(400000)) - 200000);
      default: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  task automatic test_directed;
    send_point(24'd0, 24'd0, 24'd0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_point(24'd1000, 24'd50000, 24'd0);
    send_point(24'd1000, -24'sd50000, 24'd0);
    send_point(-24'sd900000, 24'd200000, 24'd300000);
    send_point(24'd5000, 24'd0, 24'd5000);
    drain();
    write_reg(REG_CAMERA_Y, -24'sd2000);
    send_point(24'd3000, -24'sd5000, 24'd0);
    send_point(24'd3000, 24'd500000, 24'd0);
    send_point(24'd3000, -24'sd2000, 24'd0);
    drain();
    write_reg(REG_CAMERA_Y, 24'd300000);
    send_point(24'd100, 24'd400000, 24'd100);
    send_point(24'd100, 24'd300000, 24'd100);
    send_point(24'd100, -24'sd300000, 24'd100);
    drain();
    // inverted slab and zero divisors
    write_reg(REG_FOG_FLOOR, 24'd200000);
    write_reg(REG_FOG_CEILING, -24'sd100000);
    write_reg(REG_DEPTH_RANGE, 24'd0);
    write_reg(REG_FAR_DIST, 24'd0);
    send_point(24'd0, 24'd0, 24'd0);
    send_point(24'd10, -24'sd150000, 24'd20);
    send_point(24'd10, 24'd500000, 24'd20);
    drain();
    write_reg(3'd7, 24'h123456);
    write_reg(REG_DEPTH_RANGE, 24'd1);
    write_reg(REG_FAR_DIST, 24'h7FFFFF);
    send_point(24'd7, 24'd250000, 24'd9);
    drain();
  endtask

  task automatic test_random_phase(input int n);
    for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  task automatic randomize_config;
    write_reg(REG_CAMERA_X, rand_coord());
    write_reg(REG_CAMERA_Y, rand_coord());
    write_reg(REG_CAMERA_Z, rand_coord());
    write_reg(REG_FOG_FLOOR, rand_coord());
    write_reg(REG_FOG_CEILING, rand_coord());
    write_reg(REG_DEPTH_RANGE,
              COORD_W'($urandom_range(2) == 0 ? $urandom : $urandom_range(1, 900000)));
    write_reg(REG_FAR_DIST,
              COORD_W'($urandom_range(2) == 0 ? $urandom : $urandom_range(1, 6000000)));
  endtask

  task automatic test_random;
    push_idle_pct = 22;
    pop_idle_pct = 60;
    test_random_phase(120);
    randomize_config();
    test_random_phase(130);
    push_idle_pct = 60;
    pop_idle_pct = 22;
    write_reg(REG_FOG_FLOOR, -24'sd40000);
    write_reg(REG_FOG_CEILING, 24'd60000);
    test_random_phase(130);
    randomize_config();
    test_random_phase(120);
    push_idle_pct = 0;
    pop_idle_pct = 0;
    write_reg(REG_CAMERA_X, 24'h800000);
    write_reg(REG_CAMERA_Y, 24'h7FFFFF);
    write_reg(REG_CAMERA_Z, 24'h800000);
    write_reg(REG_FAR_DIST, 24'h7FFFFF);
    test_random_phase(125);
    randomize_config();
    test_random_phase(125);
  endtask

  initial begin
    cfg = '{camera_x: '0, camera_y: '0, camera_z: '0, fog_floor: '0,
            fog_ceiling: FOG_CEILING_RESET, fog_depth_range: DEPTH_RANGE_RESET,
            far_distance: FAR_DIST_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
